// ===== rtl/expiring_token_table_source_caps_macros.svh =====
// Assertion macros for the token table checker.
`ifndef EXPIRING_TOKEN_TABLE_SOURCE_CAPS_MACROS_SVH
`define EXPIRING_TOKEN_TABLE_SOURCE_CAPS_MACROS_SVH

// Same-cycle implication, sampled on clk, muted in reset.
`define ETTSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token table check failed");

// Next-cycle implication, sampled on clk, muted in reset.
`define ETTSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token table check failed");

`endif

// ===== rtl/ettsc_pkg.sv =====
// Shared types and constants for the token table.
package ettsc_pkg;

    localparam logic [1:0] MODE_ISSUE   = 2'd0;
    localparam logic [1:0] MODE_CONSUME = 2'd1;
    localparam logic [1:0] MODE_SWEEP   = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    localparam logic [1:0] CFG_TTL      = 2'd0;
    localparam logic [1:0] CFG_MAX_ADDR = 2'd1;
    localparam logic [1:0] CFG_MAX_TOT  = 2'd2;

    localparam logic [31:0] TTL_RESET      = 32'd60;
    localparam logic [6:0]  MAX_ADDR_RESET = 7'd4;
    localparam logic [6:0]  MAX_TOT_RESET  = 7'd64;

    typedef struct packed {
        logic        valid;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] expiry;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [63:0] material;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic clr;     // clearing pass: write invalid at scan index
        logic load;    // capture item, zero accumulators
        logic scan;    // read next slot
        logic commit;  // insert if allowed, load result beat
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;  // scan index at last slot
        logic out_free;  // result register can take a beat
    } stat_t;

endpackage

// ===== rtl/ettsc_ctrl.sv =====
// Sequencer for clearing pass, slot scan and commit.
module ettsc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ettsc_pkg::stat_t stat,
    output ettsc_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ettsc_dp.sv =====
// Token store, scan accumulators, config registers and result register.
module ettsc_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ettsc_pkg::cmd_t  cmd,
    output ettsc_pkg::stat_t stat,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic [1:0]       mode,
    input  logic [63:0]      key_id_high,
    input  logic [63:0]      key_id_low,
    input  logic [63:0]      client_addr_high,
    input  logic [63:0]      client_addr_low,
    input  logic [63:0]      material_in,
    input  logic [31:0]      current_time,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             accepted,
    output logic [63:0]      material_out,
    output logic [6:0]       removed_count,
    output logic [6:0]       total_entries,
    output logic [6:0]       addr_outstanding
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = CW + 7;
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);

    ettsc_pkg::entry_t mem [TABLE_DEPTH];

    logic [31:0] ttl_reg;
    logic [6:0]  max_addr_reg, max_tot_reg;

    logic [1:0]  mode_reg;
    logic [63:0] key_high_reg, key_low_reg, addr_high_reg, addr_low_reg, mat_in_reg;
    logic [31:0] now_reg;

    logic [IW-1:0] idx_reg, eval_idx_reg, free_idx_reg;
    logic          eval_vld_reg;
    ettsc_pkg::entry_t rd_reg;

    logic [CW-1:0] total_reg, per_reg, removed_reg;
    logic          dup_reg, found_reg, free_found_reg, acc_reg;
    logic [63:0]   mat_hit_reg;

    logic          out_valid_reg, acc_out_reg;
    logic [63:0]   mat_out_reg;
    logic [6:0]    rem_out_reg, tot_out_reg, per_out_reg;

    // slot evaluation
    logic expired, key_hit, addr_hit, kill, keep, take;
    logic [32:0] exp_sum;
    logic [31:0] new_expiry;
    logic        issue_ok;
    logic [XW-1:0] tot_x, per_x, rem_x, maxt_x, maxa_x;
    logic [XW-1:0] tot_sum, per_sum;

    assign expired  = (now_reg >= rd_reg.expiry);
    assign key_hit  = (rd_reg.key_high == key_high_reg) && (rd_reg.key_low == key_low_reg);
    assign addr_hit = (rd_reg.addr_high == addr_high_reg) && (rd_reg.addr_low == addr_low_reg);

    always_comb
    begin
        kill = 1'b0;
        take = 1'b0;
        case (mode_reg)
            ettsc_pkg::MODE_ISSUE, ettsc_pkg::MODE_SWEEP:
            begin
                kill = rd_reg.valid && expired;
            end
            ettsc_pkg::MODE_CONSUME:
            begin
                take = rd_reg.valid && key_hit && !found_reg;
                kill = take;
            end
            default:
            begin
                kill = 1'b0;
            end
        endcase
        keep = rd_reg.valid && !kill;
    end

    assign exp_sum    = {1'b0, now_reg} + {1'b0, ttl_reg};
    assign new_expiry = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

    assign tot_x  = XW'(total_reg);
    assign per_x  = XW'(per_reg);
    assign rem_x  = XW'(removed_reg);
    assign maxt_x = XW'(max_tot_reg);
    assign maxa_x = XW'(max_addr_reg);

    assign tot_sum = tot_x + XW'(issue_ok);
    assign per_sum = per_x + XW'(issue_ok);

    assign issue_ok = (mode_reg == ettsc_pkg::MODE_ISSUE) && !dup_reg && (tot_x < maxt_x)
                    && !((per_reg != '0) && (per_x >= maxa_x)) && free_found_reg;

    assign stat.idx_last = (idx_reg == IDX_LAST);
    assign stat.out_free = !out_valid_reg || out_ready;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg      <= ettsc_pkg::TTL_RESET;
            max_addr_reg <= ettsc_pkg::MAX_ADDR_RESET;
            max_tot_reg  <= ettsc_pkg::MAX_TOT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ettsc_pkg::CFG_TTL:      ttl_reg      <= cfg_data;
                ettsc_pkg::CFG_MAX_ADDR: max_addr_reg <= cfg_data[6:0];
                ettsc_pkg::CFG_MAX_TOT:  max_tot_reg  <= cfg_data[6:0];
                default:                 ;
            endcase
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            mem[idx_reg] <= '0;
        end
        else if (eval_vld_reg && kill)
        begin
            mem[eval_idx_reg] <= {1'b0, rd_reg[$bits(ettsc_pkg::entry_t)-2:0]};
        end
        else if (cmd.commit && issue_ok)
        begin
            mem[free_idx_reg] <= '{valid: 1'b1, key_high: key_high_reg,
                                   key_low: key_low_reg, expiry: new_expiry,
                                   addr_high: addr_high_reg, addr_low: addr_low_reg,
                                   material: mat_in_reg};
        end
        if (cmd.scan)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg      <= mode;
            key_high_reg  <= key_id_high;
            key_low_reg   <= key_id_low;
            addr_high_reg <= client_addr_high;
            addr_low_reg  <= client_addr_low;
            mat_in_reg    <= material_in;
            now_reg       <= current_time;
        end
        if (cmd.scan)
        begin
            eval_idx_reg <= idx_reg;
        end
    end

    // scan index and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            eval_vld_reg   <= 1'b0;
            total_reg      <= '0;
            per_reg        <= '0;
            removed_reg    <= '0;
            dup_reg        <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            acc_reg        <= 1'b0;
            mat_hit_reg    <= '0;
        end
        else
        begin
            eval_vld_reg <= cmd.scan;
            if (cmd.clr || cmd.scan)
            begin
                idx_reg <= stat.idx_last ? '0 : idx_reg + 1'b1;
            end
            if (cmd.load)
            begin
                total_reg      <= '0;
                per_reg        <= '0;
                removed_reg    <= '0;
                dup_reg        <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                acc_reg        <= 1'b0;
                mat_hit_reg    <= '0;
            end
            else if (eval_vld_reg)
            begin
                if (keep)
                begin
                    total_reg <= total_reg + 1'b1;
                    if (addr_hit)
                    begin
                        per_reg <= per_reg + 1'b1;
                    end
                    if (key_hit && (mode_reg == ettsc_pkg::MODE_ISSUE))
                    begin
                        dup_reg <= 1'b1;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= eval_idx_reg;
                end
                if (kill && (mode_reg != ettsc_pkg::MODE_CONSUME))
                begin
                    removed_reg <= removed_reg + 1'b1;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                    if (expired)
                    begin
                        removed_reg <= CW'(1);
                    end
                    else
                    begin
                        acc_reg     <= 1'b1;
                        mat_hit_reg <= rd_reg.material;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            acc_out_reg <= acc_reg || issue_ok;
            mat_out_reg <= mat_hit_reg;
            rem_out_reg <= rem_x[6:0];
            tot_out_reg <= tot_sum[6:0];
            per_out_reg <= per_sum[6:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = acc_out_reg;
    assign material_out     = mat_out_reg;
    assign removed_count    = rem_out_reg;
    assign total_entries    = tot_out_reg;
    assign addr_outstanding = per_out_reg;

endmodule

// ===== rtl/expiring_token_table_source_caps.sv =====
// Top level of the expiring single-use token table.
//
//  channel | signals                        | beat
//  --------+--------------------------------+------------------------------
//  in      | in_valid / in_ready            | mode, id, address, material, time
//  out     | out_valid / out_ready          | accepted, material, counts
//  cfg     | cfg_we, cfg_index, cfg_data    | one register write, no stall
//
//  The result beat is presented after the input beat is taken, once the
//  scan has made one read of the slot store per cycle over every slot, the
//  read register has drained and the commit has loaded the result register.
//  in_ready is high only in the idle state, so the next item is taken only
//  after the last one commits. After reset a clearing pass invalidates
//  every slot; in_ready stays low meanwhile.
//  A waiting result beat does not block the next item; only the commit
//  waits for the result register to free up.
module expiring_token_table_source_caps #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [63:0] key_id_high,
    input  logic [63:0] key_id_low,
    input  logic [63:0] client_addr_high,
    input  logic [63:0] client_addr_low,
    input  logic [63:0] material_in,
    input  logic [31:0] current_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [63:0] material_out,
    output logic [6:0]  removed_count,
    output logic [6:0]  total_entries,
    output logic [6:0]  addr_outstanding
);

    ettsc_pkg::cmd_t  cmd;
    ettsc_pkg::stat_t stat;

    // sequencer: clearing pass, scan, commit
    ettsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot store and per-item accumulators
    ettsc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .key_id_high      (key_id_high),
        .key_id_low       (key_id_low),
        .client_addr_high (client_addr_high),
        .client_addr_low  (client_addr_low),
        .material_in      (material_in),
        .current_time     (current_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .accepted         (accepted),
        .material_out     (material_out),
        .removed_count    (removed_count),
        .total_entries    (total_entries),
        .addr_outstanding (addr_outstanding)
    );

endmodule

// ===== rtl/ettsc_checker.sv =====
// Port-level checker for the token table, with its bind.
`include "expiring_token_table_source_caps_macros.svh"

module ettsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        accepted,
    input logic [63:0] material_out,
    input logic [6:0]  removed_count
);

    // a held result beat stays
    `ETTSC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    // one item at a time: busy after acceptance
    `ETTSC_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready)
    // material only leaves with an accepted beat
    `ETTSC_ASSERT_IMP(a_mat_zero, out_valid && !accepted, material_out == 64'd0)
    // no result beat appears in the cycle after an acceptance that found none waiting
    `ETTSC_ASSERT_NXT(a_no_early_out, in_valid && in_ready && !out_valid, !out_valid)
    // never more removals than the table holds
    `ETTSC_ASSERT_IMP(a_rem_range, out_valid, removed_count <= 7'd64)

endmodule

bind expiring_token_table_source_caps ettsc_checker u_ettsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .material_out  (material_out),
    .removed_count (removed_count)
);

// ===== tb/expiring_token_table_source_caps_tb.sv =====
// Self-checking testbench for the expiring token table with source caps.
`timescale 1ns / 100ps

module expiring_token_table_source_caps_tb;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PER_PH = 75;

    // One input beat, all fields at the block's widths.
    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] kh;
        logic [63:0] kl;
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] mat;
        logic [31:0] now;
    } token_req_t;

    // One result beat.
    typedef struct packed {
        logic        acc;
        logic [63:0] mat;
        logic [6:0]  removed;
        logic [6:0]  total;
        logic [6:0]  per_addr;
    } token_verdict_t;

    // Directed row: the beat, plus a hand-typed verdict where it is obvious.
    typedef struct packed {
        token_req_t     req;
        logic           typed;
        token_verdict_t verdict;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [63:0] key_id_high;
    logic [63:0] key_id_low;
    logic [63:0] client_addr_high;
    logic [63:0] client_addr_low;
    logic [63:0] material_in;
    logic [31:0] current_time;
    logic        out_valid;
    logic        out_ready;
    logic        accepted;
    logic [63:0] material_out;
    logic [6:0]  removed_count;
    logic [6:0]  total_entries;
    logic [6:0]  addr_outstanding;

    // Shadow copy of the token table and its registers.
    logic        tok_valid [DEPTH];
    logic [63:0] tok_kh    [DEPTH];
    logic [63:0] tok_kl    [DEPTH];
    logic [31:0] tok_exp   [DEPTH];
    logic [63:0] tok_ah    [DEPTH];
    logic [63:0] tok_al    [DEPTH];
    logic [63:0] tok_mat   [DEPTH];
    logic [31:0] ttl_cfg;
    logic [6:0]  addr_cap;
    logic [6:0]  total_cap;

    token_verdict_t verdict_q [$];
    stim_row_t      rows      [$];
    logic [63:0]    key_pool  [12];
    logic [63:0]    addr_pool [4][2];

    int  fail_count;
    int  cycles;
    bit  steady;     // set for the last stretch: no stalls on either side
    int  sink_stall;

    expiring_token_table_source_caps #(.TABLE_DEPTH(DEPTH)) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .key_id_high      (key_id_high),
        .key_id_low       (key_id_low),
        .client_addr_high (client_addr_high),
        .client_addr_low  (client_addr_low),
        .material_in      (material_in),
        .current_time     (current_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .accepted         (accepted),
        .material_out     (material_out),
        .removed_count    (removed_count),
        .total_entries    (total_entries),
        .addr_outstanding (addr_outstanding)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------
    // Predictor helpers over the shadow table
    // ---------------------------------------------------------------
    function automatic int purge_expired(input logic [31:0] now);
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (tok_valid[i] && now >= tok_exp[i])
            begin
                tok_valid[i] = 1'b0;
                n++;
            end
        end
        return n;
    endfunction

    function automatic int count_live();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (tok_valid[i])
                n++;
        return n;
    endfunction

    function automatic int count_addr(input logic [63:0] ah, input logic [63:0] al);
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (tok_valid[i] && tok_ah[i] == ah && tok_al[i] == al)
                n++;
        return n;
    endfunction

    // Returns the slot holding the id, or DEPTH when absent.
    function automatic int find_token(input logic [63:0] kh, input logic [63:0] kl);
        for (int i = 0; i < DEPTH; i++)
            if (tok_valid[i] && tok_kh[i] == kh && tok_kl[i] == kl)
                return i;
        return DEPTH;
    endfunction

    // Apply one beat to the shadow table and work out its result.
    task automatic predict_verdict(input token_req_t r, output token_verdict_t v);
        int          removed;
        int          total;
        int          per;
        int          slot;
        int          hit;
        logic [32:0] sum;
        begin
            v       = '0;
            removed = 0;
            case (r.mode)
                ettsc_pkg::MODE_ISSUE:
                begin
                    removed = purge_expired(r.now);
                    total   = count_live();
                    per     = count_addr(r.ah, r.al);
                    hit     = find_token(r.kh, r.kl);
                    slot    = DEPTH;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!tok_valid[i])
                            slot = i;
                    // an address with no live token is never capped
                    if (hit == DEPTH && total < int'(total_cap)
                        && !(per > 0 && per >= int'(addr_cap)) && slot < DEPTH)
                    begin
                        sum             = {1'b0, r.now} + {1'b0, ttl_cfg};
                        tok_valid[slot] = 1'b1;
                        tok_kh[slot]    = r.kh;
                        tok_kl[slot]    = r.kl;
                        tok_exp[slot]   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        tok_ah[slot]    = r.ah;
                        tok_al[slot]    = r.al;
                        tok_mat[slot]   = r.mat;
                        v.acc           = 1'b1;
                    end
                end
                ettsc_pkg::MODE_CONSUME:
                begin
                    hit = find_token(r.kh, r.kl);
                    if (hit < DEPTH)
                    begin
                        tok_valid[hit] = 1'b0;
                        if (r.now >= tok_exp[hit])
                            removed = 1;
                        else
                        begin
                            v.acc = 1'b1;
                            v.mat = tok_mat[hit];
                        end
                    end
                end
                ettsc_pkg::MODE_SWEEP:
                    removed = purge_expired(r.now);
                default:
                    ;
            endcase
            v.removed  = 7'(removed);
            v.total    = 7'(count_live());
            v.per_addr = 7'(count_addr(r.ah, r.al));
        end
    endtask

    // ---------------------------------------------------------------
    // Source side: present a beat at the falling edge, hold it until taken
    // ---------------------------------------------------------------
    task automatic send_req(input token_req_t r, input logic typed,
                            input token_verdict_t typed_v);
        token_verdict_t v;
        int             gap;
        begin
            // random gap before the beat, never once the run is steady
            if (!steady && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            in_valid         = 1'b1;
            mode             = r.mode;
            key_id_high      = r.kh;
            key_id_low       = r.kl;
            client_addr_high = r.ah;
            client_addr_low  = r.al;
            material_in      = r.mat;
            current_time     = r.now;
            do
                @(posedge clk);
            while (!in_ready);
            predict_verdict(r, v);
            verdict_q.push_back(typed ? typed_v : v);
        end
    endtask

    // Wait for every result, then let the block settle before a register write.
    task automatic drain();
        begin
            @(negedge clk);
            in_valid = 1'b0;
            while (verdict_q.size() != 0)
                @(posedge clk);
            repeat (DEPTH + 8) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        begin
            @(negedge clk);
            in_valid  = 1'b0;
            cfg_we    = 1'b1;
            cfg_index = idx;
            cfg_data  = val;
            @(negedge clk);
            cfg_we    = 1'b0;
            case (idx)
                ettsc_pkg::CFG_TTL:      ttl_cfg   = val;
                ettsc_pkg::CFG_MAX_ADDR: addr_cap  = val[6:0];
                ettsc_pkg::CFG_MAX_TOT:  total_cap = val[6:0];
                default:                 ;
            endcase
        end
    endtask

    function automatic stim_row_t mk_row(input logic [1:0] m, input logic [63:0] kh,
                                         input logic [63:0] kl, input logic [63:0] ah,
                                         input logic [63:0] al, input logic [63:0] mat,
                                         input logic [31:0] now, input logic typed,
                                         input token_verdict_t v);
        stim_row_t s;
        s.req     = '{m, kh, kl, ah, al, mat, now};
        s.typed   = typed;
        s.verdict = v;
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Sink side: random stall bursts on out_ready
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (steady)
            out_ready <= 1'b1;
        else if (sink_stall > 0)
        begin
            sink_stall <= sink_stall - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            sink_stall <= $urandom_range(0, 5);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Result checker: each taken beat against the oldest expectation.
    always @(posedge clk)
    begin
        token_verdict_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                e = verdict_q.pop_front();
                if (accepted !== e.acc)
                begin
                    $error("accepted: expected %0d, got %0d", e.acc, accepted);
                    fail_count++;
                end
                if (material_out !== e.mat)
                begin
                    $error("material_out: expected %h, got %h", e.mat, material_out);
                    fail_count++;
                end
                if (removed_count !== e.removed)
                begin
                    $error("removed_count: expected %0d, got %0d", e.removed, removed_count);
                    fail_count++;
                end
                if (total_entries !== e.total)
                begin
                    $error("total_entries: expected %0d, got %0d", e.total, total_entries);
                    fail_count++;
                end
                if (addr_outstanding !== e.per_addr)
                begin
                    $error("addr_outstanding: expected %0d, got %0d",
                           e.per_addr, addr_outstanding);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("expiring_token_table_source_caps verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        token_verdict_t zero_v;
        token_verdict_t v;
        token_req_t     r;
        logic [63:0]    ones;
        logic [31:0]    now;
        int             ki;
        int             ai;
        int             pick;

        fail_count       = 0;
        cycles           = 0;
        steady           = 1'b0;
        sink_stall       = 0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = ettsc_pkg::CFG_TTL;
        cfg_data         = '0;
        in_valid         = 1'b0;
        out_ready        = 1'b0;
        mode             = ettsc_pkg::MODE_QUERY;
        key_id_high      = '0;
        key_id_low       = '0;
        client_addr_high = '0;
        client_addr_low  = '0;
        material_in      = '0;
        current_time     = '0;
        ttl_cfg          = ettsc_pkg::TTL_RESET;
        addr_cap         = ettsc_pkg::MAX_ADDR_RESET;
        total_cap        = ettsc_pkg::MAX_TOT_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            tok_valid[i] = 1'b0;
            tok_kh[i]    = '0;
            tok_kl[i]    = '0;
            tok_exp[i]   = '0;
            tok_ah[i]    = '0;
            tok_al[i]    = '0;
            tok_mat[i]   = '0;
        end
        for (int i = 0; i < 12; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < 4; i++)
        begin
            addr_pool[i][0] = {$urandom, $urandom};
            addr_pool[i][1] = {$urandom, $urandom};
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset settings (ttl 60, 4 per address, 64 total).
        zero_v = '0;
        ones   = '1;
        // fresh table: query and unknown consume give all zeros
        rows.push_back(mk_row(ettsc_pkg::MODE_QUERY, 64'd1, 64'd1, 64'd7, 64'd7, 64'd0,
                              32'd0, 1'b1, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_CONSUME, 64'd1, 64'd1, 64'd7, 64'd7, 64'd0,
                              32'd1, 1'b1, zero_v));
        v = '{1'b1, 64'd0, 7'd0, 7'd1, 7'd1};
        rows.push_back(mk_row(ettsc_pkg::MODE_ISSUE, 64'd1, 64'd1, 64'd7, 64'd7, 64'hAA,
                              32'd10, 1'b1, v));
        // duplicate id: refused, counts unchanged
        v = '{1'b0, 64'd0, 7'd0, 7'd1, 7'd1};
        rows.push_back(mk_row(ettsc_pkg::MODE_ISSUE, 64'd1, 64'd1, 64'd7, 64'd7, 64'hBB,
                              32'd11, 1'b1, v));
        for (int i = 2; i <= 5; i++)   // last one runs into the per-address cap
            rows.push_back(mk_row(ettsc_pkg::MODE_ISSUE, 64'(i), 64'(i), 64'd7, 64'd7,
                                  64'(i * 16), 32'(11 + i), 1'b0, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_ISSUE, 64'd9, 64'd9, 64'd8, 64'd8, 64'h99,
                              32'd20, 1'b0, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_CONSUME, 64'd2, 64'd2, 64'd7, 64'd7, 64'd0,
                              32'd30, 1'b0, zero_v));
        // consume after expiry: removed, no material
        rows.push_back(mk_row(ettsc_pkg::MODE_CONSUME, 64'd3, 64'd3, 64'd7, 64'd7, 64'd0,
                              32'd100, 1'b0, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_QUERY, 64'd0, 64'd0, 64'd7, 64'd7, 64'd0,
                              32'd101, 1'b0, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_SWEEP, 64'd0, 64'd0, 64'd8, 64'd8, 64'd0,
                              32'd200, 1'b0, zero_v));
        // all-ones fields near the top of time: expiry saturates
        rows.push_back(mk_row(ettsc_pkg::MODE_ISSUE, ones, ones, ones, ones, ones,
                              32'hFFFF_FFF0, 1'b0, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_CONSUME, ones, ones, ones, ones, 64'd0,
                              32'hFFFF_FFFE, 1'b0, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_ISSUE, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
                              32'd0, 1'b0, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_ISSUE, ones, 64'd5, 64'd0, 64'd0, 64'h5A5A,
                              32'hFFFF_FFF8, 1'b0, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_QUERY, ones, ones, 64'd0, 64'd0, ones,
                              32'hFFFF_FFFF, 1'b0, zero_v));
        rows.push_back(mk_row(ettsc_pkg::MODE_SWEEP, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
                              32'hFFFF_FFFF, 1'b0, zero_v));
        foreach (rows[i])
            send_req(rows[i].req, rows[i].typed, rows[i].verdict);

        // Random phases, each under its own register setting; extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    write_reg(ettsc_pkg::CFG_TTL, 32'd30);
                    write_reg(ettsc_pkg::CFG_MAX_ADDR, 32'd4);
                    write_reg(ettsc_pkg::CFG_MAX_TOT, 32'd64);
                end
                1:
                begin
                    write_reg(ettsc_pkg::CFG_TTL, 32'd0);
                    write_reg(ettsc_pkg::CFG_MAX_ADDR, 32'd0);
                    write_reg(ettsc_pkg::CFG_MAX_TOT, 32'd0);
                end
                2:
                begin
                    write_reg(ettsc_pkg::CFG_TTL, 32'hFFFF_FFFF);
                    write_reg(ettsc_pkg::CFG_MAX_ADDR, 32'd64);
                    write_reg(ettsc_pkg::CFG_MAX_TOT, 32'd64);
                end
                3:
                begin
                    write_reg(ettsc_pkg::CFG_TTL, 32'd100);
                    write_reg(ettsc_pkg::CFG_MAX_ADDR, 32'd1);
                    write_reg(ettsc_pkg::CFG_MAX_TOT, 32'd8);
                end
                4:
                begin
                    write_reg(ettsc_pkg::CFG_TTL, $urandom_range(5, 400));
                    write_reg(ettsc_pkg::CFG_MAX_ADDR, $urandom_range(0, 64));
                    write_reg(ettsc_pkg::CFG_MAX_TOT, $urandom_range(0, 64));
                end
                default:
                begin
                    write_reg(ettsc_pkg::CFG_TTL, 32'd50);
                    write_reg(ettsc_pkg::CFG_MAX_ADDR, 32'd2);
                    write_reg(ettsc_pkg::CFG_MAX_TOT, 32'd64);
                    steady = 1'b1;   // last stretch runs flat out
                end
            endcase
            // phase base time: anywhere, sometimes right under the wrap
            now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : $urandom;
            for (int n = 0; n < RAND_PER_PH; n++)
            begin
                pick = $urandom_range(0, 99);
                r.mode = (pick < 45) ? ettsc_pkg::MODE_ISSUE :
                         (pick < 75) ? ettsc_pkg::MODE_CONSUME :
                         (pick < 85) ? ettsc_pkg::MODE_SWEEP : ettsc_pkg::MODE_QUERY;
                ki = $urandom_range(0, 11);
                ai = $urandom_range(0, 3);
                // mostly pooled ids so consumes and duplicates hit; some fresh ones
                if ($urandom_range(0, 4) == 0)
                begin
                    r.kh = {$urandom, $urandom};
                    r.kl = {$urandom, $urandom};
                end
                else
                begin
                    r.kh = key_pool[ki];
                    r.kl = key_pool[(ki + 5) % 12];
                end
                if ($urandom_range(0, 6) == 0)
                begin
                    r.ah = {$urandom, $urandom};
                    r.al = {$urandom, $urandom};
                end
                else
                begin
                    r.ah = addr_pool[ai][0];
                    r.al = addr_pool[ai][1];
                end
                r.mat = {$urandom, $urandom};
                now   = now + (($urandom_range(0, 19) == 0) ? $urandom_range(0, 600)
                                                            : $urandom_range(0, 15));
                r.now = now;
                send_req(r, 1'b0, zero_v);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        drain();
        if (fail_count == 0)
            $display("expiring_token_table_source_caps verification clean");
        else
            $display("expiring_token_table_source_caps verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ettsc_pkg.sv
rtl/ettsc_ctrl.sv
rtl/ettsc_dp.sv
rtl/expiring_token_table_source_caps.sv
rtl/ettsc_checker.sv
tb/expiring_token_table_source_caps_tb.sv
